// ===== hdl/pgd_pkg.sv =====
// Shared types, constants and helpers for the peak meter with accelerating falloff.
package pgd_pkg;

  // Number of meter channels held in the state memory.
  localparam int CHANNELS = 32;
  localparam int AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths.
  localparam int ChanW = 5;
  localparam int LevelW = 17;
  localparam int StepW = 8;
  localparam int AccelW = 16;
  localparam int UseW = 6;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;

  // Full scale level 1.0 in unsigned 1.16 and the step counter ceiling.
  localparam logic [LevelW-1:0] LevelOne = LevelW'(65536);
  localparam logic [StepW-1:0] StepMax = StepW'(255);
  localparam logic [UseW-1:0] UseReset = UseW'(32);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFallAccel = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgChanUse = CfgIdxW'(1);

  typedef struct packed {
    logic [ChanW-1:0]  channel;
    logic [LevelW-1:0] level_in;
  } in_item_t;

  typedef struct packed {
    logic [LevelW-1:0] peak_out;
    logic              bad_channel;
  } out_item_t;

  // One channel entry of the state memory.
  typedef struct packed {
    logic [LevelW-1:0] peak;
    logic [StepW-1:0]  steps;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Map a channel index onto a memory address.
  function automatic logic [AddrW-1:0] chan_addr(input logic [ChanW-1:0] ch);
    logic [31:0] wide;
    wide = 32'(ch);
    return wide[AddrW-1:0];
  endfunction

endpackage

// ===== hdl/pgd_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module pgd_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pgd_update.sv =====
// Peak update datapath: saturation, refresh or accelerating fall of one channel entry.
module pgd_update import pgd_pkg::*; (
  input  entry_t              cur_i,
  input  logic [LevelW-1:0]   level_i,
  input  logic [AccelW-1:0]   accel_i,
  output entry_t              nxt_o
);

  logic [LevelW-1:0]          lvl_sat;
  logic [StepW:0]             odd;
  logic [AccelW+StepW:0]      drop;
  logic [AccelW+StepW:0]      peak_wide;

  // Clamp the level to full scale.
  assign lvl_sat = (level_i > LevelOne) ? LevelOne : level_i;

  // The fall per step is accel * (2n - 1), nothing on the first step.
  assign odd = (cur_i.steps == '0) ? '0 : ({cur_i.steps, 1'b1} - (StepW+1)'(2));
  assign drop = (AccelW+StepW+1)'(accel_i) * (AccelW+StepW+1)'(odd);
  assign peak_wide = (AccelW+StepW+1)'(cur_i.peak);

  always_comb begin
    nxt_o = cur_i;
    if (lvl_sat >= cur_i.peak) begin
      nxt_o.peak = lvl_sat;
      nxt_o.steps = '0;
    end else if (cur_i.peak != '0) begin
      if (drop >= peak_wide) begin
        nxt_o.peak = '0;
      end else begin
        nxt_o.peak = cur_i.peak - drop[LevelW-1:0];
      end
      if (cur_i.steps != StepMax) begin
        nxt_o.steps = cur_i.steps + StepW'(1);
      end
    end
  end

endmodule

// ===== hdl/multichannel_peak_gravity_decay.sv =====
// Multichannel peak meter with accelerating falloff: memory read, update, write back.
// Stage one takes each input transfer and issues the memory read; the result register
// loads when stage one advances. Throughput: one item per cycle unless the output stalls,
// set by the single read-modify-write pass over the memory, with the last write forwarded.
// Reset: configuration returns to its defaults and per-channel valid flops clear at once,
// so every channel reads as zero peak and zero steps; no clearing pass is needed.
module multichannel_peak_gravity_decay import pgd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  logic [AccelW-1:0]   accel_q;
  logic [UseW-1:0]     use_q;
  logic [CHANNELS-1:0] ent_vld_q;

  logic                in_xfer;
  logic                s1_valid_q;
  logic [ChanW-1:0]    s1_chan_q;
  logic [LevelW-1:0]   s1_level_q;
  logic                s1_vld_q;
  logic                s1_adv;
  logic                s1_bad;
  logic [AddrW-1:0]    s1_addr;

  logic                fwd_valid_q;
  logic [AddrW-1:0]    fwd_addr_q;
  entry_t              fwd_data_q;

  logic [EntryW-1:0]   rd_data;
  entry_t              cur_ent;
  entry_t              nxt_ent;
  logic                wr_en;

  logic                out_valid_q;
  out_item_t           out_q;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= '0;
      use_q <= UseReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CfgFallAccel: accel_q <= cfg_data_i[AccelW-1:0];
        CfgChanUse:   use_q <= cfg_data_i[UseW-1:0];
        default:      ;
      endcase
    end
  end

  // Handshake: the update stage moves on whenever the output register is free or draining.
  assign s1_adv = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer = in_valid_i && in_ready_o;

  // Stage one holds the item while its memory read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_chan_q <= in_data_i.channel;
      s1_level_q <= in_data_i.level_in;
      s1_vld_q <= ent_vld_q[chan_addr(in_data_i.channel)];
    end
  end

  pgd_ram #(
    .Width (EntryW),
    .Depth (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr),
    .wdata_i (nxt_ent),
    .re_i    (in_xfer),
    .raddr_i (chan_addr(in_data_i.channel)),
    .rdata_o (rd_data)
  );

  // Channel check against the active count and the memory depth.
  assign s1_addr = chan_addr(s1_chan_q);
  assign s1_bad = (UseW'(s1_chan_q) >= use_q) || (32'(s1_chan_q) >= 32'(CHANNELS));

  // Current entry: the last write wins over the memory, and a never written entry is zero.
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == s1_addr)) begin
      cur_ent = fwd_data_q;
    end else if (s1_vld_q) begin
      cur_ent = entry_t'(rd_data);
    end else begin
      cur_ent = '0;
    end
  end

  pgd_update u_update (
    .cur_i   (cur_ent),
    .level_i (s1_level_q),
    .accel_i (accel_q),
    .nxt_o   (nxt_ent)
  );

  assign wr_en = s1_adv && !s1_bad;

  // Forwarding register and per-entry valid flags follow every write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      ent_vld_q <= '0;
    end else if (wr_en) begin
      fwd_valid_q <= 1'b1;
      ent_vld_q[s1_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_addr;
      fwd_data_q <= nxt_ent;
    end
  end

  // Output register decouples the result side from the update stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.peak_out <= s1_bad ? '0 : nxt_ent.peak;
      out_q.bad_channel <= s1_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the multichannel peak meter with accelerating falloff.
module testbench import pgd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Kinds of rows in the directed stimulus table.
  typedef enum bit {
    RowReading,
    RowRegWrite
  } row_kind_e;

  typedef struct {
    row_kind_e         kind;
    in_item_t          reading;
    bit                typed;
    out_item_t         typed_res;
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] data;
  } row_t;

  // One random phase: idling, register settings and shape of the readings.
  typedef struct {
    int gap_pct;
    int stall_pct;
    int accel_lo;
    int accel_hi;
    int chan_use;
    int span;
    int refresh_pct;
    int count;
  } phase_t;

  logic                clk_i;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_idx = CfgFallAccel;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Predictor state: registers and per-channel meter entries.
  logic [AccelW-1:0] accel_q = '0;
  logic [UseW-1:0]   use_q = UseReset;
  logic [LevelW-1:0] peak_q [CHANNELS] = '{default: '0};
  logic [StepW-1:0]  steps_q [CHANNELS] = '{default: '0};

  out_item_t pending_peaks[$];
  int        mismatches = 0;
  int        send_gap_pct = 0;
  int        recv_stall_pct = 0;

  row_t   dir_rows[22];
  phase_t phases[6];

  multichannel_peak_gravity_decay u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Update one meter channel and return the peak it now holds.
  function automatic out_item_t meter_update(in_item_t rd);
    out_item_t         res;
    logic [LevelW-1:0] lvl;
    logic [31:0]       n;
    logic [31:0]       drop;
    int                ch;
    ch = int'(rd.channel);
    res = '0;
    if (32'(rd.channel) >= 32'(use_q) || ch >= CHANNELS) begin
      res.bad_channel = 1'b1;
      return res;
    end
    lvl = (rd.level_in > LevelOne) ? LevelOne : rd.level_in;
    if (lvl >= peak_q[ch]) begin
      peak_q[ch] = lvl;
      steps_q[ch] = '0;
    end else if (peak_q[ch] != '0) begin
      // The fall is 2n-1 times the acceleration, with n the steps so far; none at n = 0.
      n = 32'(steps_q[ch]);
      drop = (n == 0) ? 32'd0 : 32'(accel_q) * (2 * n - 1);
      if (drop >= 32'(peak_q[ch])) begin
        peak_q[ch] = '0;
      end else begin
        peak_q[ch] = peak_q[ch] - drop[LevelW-1:0];
      end
      if (steps_q[ch] != StepMax) begin
        steps_q[ch] = steps_q[ch] + 1'b1;
      end
    end
    res.peak_out = peak_q[ch];
    return res;
  endfunction

  // Random reading: mostly falls below the current peak of the first span channels.
  function automatic in_item_t next_reading(int span, int refresh_pct);
    in_item_t    rd;
    int unsigned ch;
    if ($urandom_range(0, 9) == 0) begin
      ch = $urandom_range(0, 31);
    end else begin
      ch = $urandom_range(0, span - 1);
    end
    rd.channel = ch[ChanW-1:0];
    if ($urandom_range(0, 99) < refresh_pct || peak_q[ch] == '0) begin
      rd.level_in = LevelW'($urandom_range(0, 131071));
    end else begin
      rd.level_in = LevelW'($urandom_range(0, 32'(peak_q[ch]) - 1));
    end
    return rd;
  endfunction

  function automatic row_t item_row(int ch, int level);
    row_t r;
    r.kind = RowReading;
    r.reading.channel = ChanW'(ch);
    r.reading.level_in = LevelW'(level);
    r.typed = 1'b0;
    r.typed_res = '0;
    r.idx = CfgFallAccel;
    r.data = '0;
    return r;
  endfunction

  function automatic row_t known_row(int ch, int level, int peak, bit bad);
    row_t r;
    r = item_row(ch, level);
    r.typed = 1'b1;
    r.typed_res.peak_out = LevelW'(peak);
    r.typed_res.bad_channel = bad;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, int data);
    row_t r;
    r = item_row(0, 0);
    r.kind = RowRegWrite;
    r.idx = idx;
    r.data = CfgDataW'(data);
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Present one reading and log its expected peak once the transfer happens.
  task automatic send_reading(in_item_t rd, bit typed, out_item_t typed_res);
    out_item_t res;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= rd;
    do @(posedge clk_i); while (!in_ready);
    res = meter_update(rd);
    pending_peaks.push_back(typed ? typed_res : res);
  endtask

  // Register writes happen only once the meter has drained.
  task automatic program_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    in_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgFallAccel: accel_q = data[AccelW-1:0];
      CfgChanUse:   use_q = data[UseW-1:0];
      default: ;
    endcase
  endtask

  // Result side: random stalls and a field-by-field check of each transfer.
  initial begin
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_n && out_valid && out_ready) begin
        if (pending_peaks.size() == 0) begin
          note_mismatch($sformatf("unexpected result: peak %0d bad %0d",
                                  out_data.peak_out, out_data.bad_channel));
        end else begin
          want = pending_peaks.pop_front();
          if (out_data.peak_out !== want.peak_out ||
              out_data.bad_channel !== want.bad_channel) begin
            note_mismatch($sformatf("mismatch: peak %0d bad %0d, expected peak %0d bad %0d",
                                    out_data.peak_out, out_data.bad_channel,
                                    want.peak_out, want.bad_channel));
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    #1000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned accel;
    in_item_t    rd;

    // Directed rows start from reset defaults: no acceleration, all channels active.
    dir_rows = '{
      known_row(0, 0, 0, 1'b0),
      known_row(31, 131071, 65536, 1'b0),
      known_row(31, 65537, 65536, 1'b0),
      known_row(31, 0, 65536, 1'b0),
      known_row(0, 65536, 65536, 1'b0),
      item_row(5, 1),
      cfg_row(CfgFallAccel, 65535),
      known_row(31, 0, 1, 1'b0),
      known_row(31, 0, 0, 1'b0),
      known_row(31, 0, 0, 1'b0),
      known_row(0, 32768, 65536, 1'b0),
      known_row(0, 32768, 1, 1'b0),
      cfg_row(CfgChanUse, 1),
      known_row(1, 5, 0, 1'b1),
      known_row(31, 131071, 0, 1'b1),
      known_row(0, 131071, 65536, 1'b0),
      cfg_row(CfgChanUse, 0),
      known_row(0, 7, 0, 1'b1),
      cfg_row(CfgChanUse, 63),
      known_row(31, 65535, 65535, 1'b0),
      item_row(20, 12345),
      cfg_row(CfgChanUse, 16'hFFE0)
    };

    // The first phase lets step counters saturate with no fall, the second
    // then falls from the saturated counter.
    phases = '{
      '{16, 71, 0, 0, 32, 2, 0, 700},
      '{16, 71, 1, 1, 32, 2, 2, 250},
      '{71, 16, 65535, 65535, 1, 4, 30, 150},
      '{71, 16, 1, 2000, 17, 32, 15, 400},
      '{0, 0, 0, 65535, 32, 32, 10, 400},
      '{0, 0, 0, 65535, 0, 8, 50, 50}
    };

    send_gap_pct = phases[0].gap_pct;
    recv_stall_pct = phases[0].stall_pct;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowRegWrite) begin
        program_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_reading(dir_rows[i].reading, dir_rows[i].typed, dir_rows[i].typed_res);
      end
    end

    // Random phases.
    foreach (phases[p]) begin
      send_gap_pct = phases[p].gap_pct;
      recv_stall_pct = phases[p].stall_pct;
      accel = $urandom_range(phases[p].accel_lo, phases[p].accel_hi);
      program_reg(CfgFallAccel, CfgDataW'(accel));
      program_reg(CfgChanUse, CfgDataW'(phases[p].chan_use));
      for (int k = 0; k < phases[p].count; k++) begin
        rd = next_reading(phases[p].span, phases[p].refresh_pct);
        send_reading(rd, 1'b0, '0);
      end
    end

    // Drain and let the pipeline settle.
    in_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pgd_pkg.sv
hdl/pgd_ram.sv
hdl/pgd_update.sv
hdl/multichannel_peak_gravity_decay.sv
verif/testbench.sv
